// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the line framer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LFC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line framer assertion failed");

// Next-cycle implication, disabled during reset.
`define LFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line framer assertion failed");

`endif

// ===== hw/rtl/lfc_pkg.sv =====
// Types, constants and helper functions of the line framer with type classifier.
package lfc_pkg;

  localparam int RING_DEPTH = 128;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int LEN_W      = 7;
  localparam int DROP_W     = 16;
  localparam int TYPE_W     = 4;
  localparam int NUM_TAGS   = 10;

  localparam logic [LEN_W-1:0] LEN_MAX    = 7'd127;
  localparam logic [LEN_W-1:0] ALPHA_LEN  = 7'd94;
  localparam logic [LEN_W-1:0] PREFIX_LEN = 7'd5;
  localparam logic [LEN_W-1:0] COMMA_POS  = 7'd22;
  localparam logic [LEN_W-1:0] QUOTE_POS  = 7'd93;

  localparam logic [TYPE_W-1:0] TYPE_UNKNOWN = 4'd0;
  localparam logic [TYPE_W-1:0] TYPE_ALPHA   = 4'd11;

  localparam logic [7:0] CHAR_BANG    = 8'h21;
  localparam logic [7:0] CHAR_BRACKET = 8'h5B;
  localparam logic [7:0] CHAR_QUOTE   = 8'h22;
  localparam logic [7:0] CHAR_COMMA   = 8'h2C;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] PRINT_LO     = 8'h20;
  localparam logic [7:0] PRINT_HI     = 8'h7E;

  // Check sequence steps: which line byte the compare unit sees.
  localparam logic [2:0] CHK_FIRST = 3'd0;
  localparam logic [2:0] CHK_TAG0  = 3'd1;
  localparam logic [2:0] CHK_TAG1  = 3'd2;
  localparam logic [2:0] CHK_TAG2  = 3'd3;
  localparam logic [2:0] CHK_TAG3  = 3'd4;
  localparam logic [2:0] CHK_COMMA = 3'd5;
  localparam logic [2:0] CHK_QUOTE = 3'd6;
  localparam logic [2:0] CHK_DONE  = 3'd7;

  typedef enum logic [1:0] {
    CMD_RX      = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LINE = 3'b010,
    S_DONE = 3'b100
  } state_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
    logic [6:0] read_index;
  } lfc_in_t;

  typedef struct packed {
    logic              is_read_reply;
    logic [TYPE_W-1:0] line_type;
    logic [LEN_W-1:0]  line_length;
    logic              bad_prefix;
    logic              alpha_valid;
    logic [DROP_W-1:0] drop_count;
    logic [7:0]        read_data;
  } lfc_out_t;

  typedef struct packed {
    logic       en;
    logic [2:0] idx;
  } lfc_chk_t;

  function automatic logic [LEN_W-1:0] chk_offset(logic [2:0] idx);
    case (idx)
      CHK_COMMA: return COMMA_POS;
      CHK_QUOTE: return QUOTE_POS;
      default:   return {4'd0, idx};
    endcase
  endfunction

  function automatic logic [31:0] tag_word(int unsigned t);
    case (t)
      0:       return "LRR:";
      1:       return "REL:";
      2:       return "EXP:";
      3:       return "RFX:";
      4:       return "AUI:";
      5:       return "KPM:";
      6:       return "KPE:";
      7:       return "CRC:";
      8:       return "VER:";
      9:       return "ERR:";
      default: return 32'd0;
    endcase
  endfunction

  function automatic logic [RING_AW-1:0] ring_wrap(logic [RING_AW-1:0] base,
                                                   logic [LEN_W-1:0] off);
    logic [RING_AW:0] sum;
    sum = {1'b0, base} + (RING_AW+1)'(off);
    if (sum >= (RING_AW+1)'(RING_DEPTH)) begin
      sum = sum - (RING_AW+1)'(RING_DEPTH);
    end
    return sum[RING_AW-1:0];
  endfunction

  function automatic logic [RING_AW-1:0] ring_next(logic [RING_AW-1:0] p);
    return (p == RING_AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

// ===== hw/rtl/lfc_ring.sv =====
// Line ring memory: one write port, one registered read port.
module lfc_ring import lfc_pkg::*; (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [RING_AW-1:0] waddr_i,
  input  logic [7:0]         wdata_i,
  input  logic               re_i,
  input  logic [RING_AW-1:0] raddr_i,
  output logic [7:0]         rdata_o
);

  logic [7:0] mem_q [RING_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/lfc_match.sv =====
// Shared byte compare unit: prefix tag match and alpha status checks.
module lfc_match import lfc_pkg::*; (
  input  logic              clk_i,
  input  lfc_chk_t          chk_i,
  input  logic [7:0]        rd_data_i,
  input  logic [LEN_W-1:0]  line_len_i,
  output logic [TYPE_W-1:0] line_type_o,
  output logic              bad_prefix_o,
  output logic              alpha_valid_o
);

  logic                bang_q;
  logic                brk_q;
  logic                comma_q;
  logic                quote_q;
  logic [NUM_TAGS-1:0] mask_q;
  logic [NUM_TAGS-1:0] hit;
  logic [1:0]          char_sel;
  logic [31:0]         tag_chars;
  logic [TYPE_W-1:0]   tag_type;

  assign char_sel = 2'd3 - 2'(chk_i.idx - 3'd1);

  always_comb begin
    tag_chars = '0;
    for (int unsigned t = 0; t < NUM_TAGS; t++) begin
      tag_chars = tag_word(t);
      hit[t]    = (rd_data_i == tag_chars[{char_sel, 3'b000} +: 8]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (chk_i.en) begin
      case (chk_i.idx)
        CHK_FIRST: begin
          bang_q <= (rd_data_i == CHAR_BANG);
          brk_q  <= (rd_data_i == CHAR_BRACKET);
          mask_q <= '1;
        end
        CHK_TAG0, CHK_TAG1, CHK_TAG2, CHK_TAG3: begin
          mask_q <= mask_q & hit;
        end
        CHK_COMMA: begin
          comma_q <= (rd_data_i == CHAR_COMMA);
        end
        CHK_QUOTE: begin
          quote_q <= (rd_data_i == CHAR_QUOTE);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    tag_type = TYPE_UNKNOWN;
    for (int t = NUM_TAGS - 1; t >= 0; t--) begin
      if (mask_q[t]) begin
        tag_type = TYPE_W'(t + 1);
      end
    end
  end

  always_comb begin
    if (brk_q) begin
      line_type_o = TYPE_ALPHA;
    end else if (bang_q && (line_len_i >= PREFIX_LEN)) begin
      line_type_o = tag_type;
    end else begin
      line_type_o = TYPE_UNKNOWN;
    end
  end

  assign bad_prefix_o  = !bang_q && !brk_q;
  assign alpha_valid_o = brk_q && (line_len_i == ALPHA_LEN) && comma_q && quote_q;

endmodule

// ===== hw/rtl/line_framer_with_type_classifier_core.sv =====
// Top level of the line framer with type classifier.
//
// Input channel in_valid_i/in_ready_o carries one command per transfer: a
// received byte, a read of one byte of the last completed line, or a parser
// restart. Output channel out_valid_o/out_ready_i carries end-of-line
// reports and read replies, held in an output register.
// A printable received byte that does not close a line is written into the
// ring in the cycle of its transfer, and the block stays ready.
// A CR or LF closing a line starts an eight-step check sequence: the ring's
// single read port fetches line bytes 0 to 4, 22 and 93, one per cycle, into
// the shared compare unit. The report is loaded into the output register
// from S_DONE, once that register is free; a read command takes one ring read
// and its reply is loaded the same way. No new command is taken before that.
// in_ready_o is low while a check or read is in progress or while a finished
// result waits on a stalled receiver with the output register still full.
// Reset clears the parser, pointers, last-line record and drop counter; ring
// contents are not cleared and need no clearing pass.
`include "assert_macros.svh"

module line_framer_with_type_classifier_core import lfc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  lfc_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lfc_out_t out_data_o
);

  state_e             state_q, state_d;
  logic [2:0]         step_q, step_d;
  logic               reply_q, reply_d;
  logic [LEN_W-1:0]   ridx_q, ridx_d;
  logic               scan_q, scan_d;
  logic [RING_AW-1:0] wr_pos_q, wr_pos_d;
  logic [RING_AW-1:0] rd_pos_q, rd_pos_d;
  logic [RING_AW-1:0] last_start_q, last_start_d;
  logic [LEN_W-1:0]   last_len_q, last_len_d;
  logic [DROP_W-1:0]  drops_q, drops_d;
  logic               out_valid_q, out_valid_d;
  lfc_out_t           out_q, out_d;

  logic               ram_we;
  logic               ram_re;
  logic [RING_AW-1:0] ram_raddr;
  logic [7:0]         ram_rdata;
  lfc_chk_t           chk;
  logic [TYPE_W-1:0]  m_type;
  logic               m_bad;
  logic               m_alpha;

  logic               printable;
  logic               eol;
  logic [RING_AW-1:0] wr_next;
  logic [RING_AW-1:0] rd_next;
  logic [RING_AW:0]   len_full;
  logic [LEN_W-1:0]   len_sat;
  lfc_out_t           result;

  assign printable = (in_data_i.rx_byte >= PRINT_LO) && (in_data_i.rx_byte <= PRINT_HI);
  assign eol       = (in_data_i.rx_byte == CHAR_CR) || (in_data_i.rx_byte == CHAR_LF);
  assign wr_next   = ring_next(wr_pos_q);
  assign rd_next   = ring_next(rd_pos_q);

  always_comb begin
    if (wr_pos_q >= rd_pos_q) begin
      len_full = {1'b0, wr_pos_q} - {1'b0, rd_pos_q};
    end else begin
      len_full = {1'b0, wr_pos_q} + (RING_AW+1)'(RING_DEPTH) - {1'b0, rd_pos_q};
    end
    len_sat = (len_full > (RING_AW+1)'(LEN_MAX)) ? LEN_MAX : len_full[LEN_W-1:0];
  end

  always_comb begin
    result = '0;
    result.line_length = last_len_q;
    result.drop_count  = drops_q;
    if (reply_q) begin
      result.is_read_reply = 1'b1;
      result.read_data     = (ridx_q < last_len_q) ? ram_rdata : 8'd0;
    end else begin
      result.line_type   = m_type;
      result.bad_prefix  = m_bad;
      result.alpha_valid = m_alpha;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    reply_d      = reply_q;
    ridx_d       = ridx_q;
    scan_d       = scan_q;
    wr_pos_d     = wr_pos_q;
    rd_pos_d     = rd_pos_q;
    last_start_d = last_start_q;
    last_len_d   = last_len_q;
    drops_d      = drops_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = ring_wrap(last_start_q, chk_offset(step_q));
    chk.en       = 1'b0;
    chk.idx      = 3'(step_q - 3'd1);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.cmd)
            CMD_RX: begin
              if (scan_q || printable) begin
                if (eol) begin
                  last_start_d = rd_pos_q;
                  last_len_d   = len_sat;
                  rd_pos_d     = wr_pos_q;
                  scan_d       = 1'b0;
                  reply_d      = 1'b0;
                  step_d       = CHK_FIRST;
                  state_d      = S_LINE;
                end else if (!printable) begin
                  // drop the partial line
                  wr_pos_d = '0;
                  rd_pos_d = '0;
                  scan_d   = 1'b0;
                end else begin
                  ram_we   = 1'b1;
                  scan_d   = 1'b1;
                  wr_pos_d = wr_next;
                  if (wr_next == rd_pos_q) begin
                    rd_pos_d = rd_next;
                    if (drops_q != '1) begin
                      drops_d = drops_q + 1'b1;
                    end
                  end
                end
              end
            end
            CMD_READ: begin
              ram_re    = 1'b1;
              ram_raddr = ring_wrap(last_start_q, in_data_i.read_index);
              ridx_d    = in_data_i.read_index;
              reply_d   = 1'b1;
              state_d   = S_DONE;
            end
            CMD_RESTART: begin
              wr_pos_d = '0;
              rd_pos_d = '0;
              scan_d   = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_LINE: begin
        ram_re = (step_q != CHK_DONE);
        chk.en = (step_q != CHK_FIRST);
        step_d = step_q + 1'b1;
        if (step_q == CHK_DONE) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = result;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= CHK_FIRST;
      reply_q      <= 1'b0;
      scan_q       <= 1'b0;
      wr_pos_q     <= '0;
      rd_pos_q     <= '0;
      last_start_q <= '0;
      last_len_q   <= '0;
      drops_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      reply_q      <= reply_d;
      scan_q       <= scan_d;
      wr_pos_q     <= wr_pos_d;
      rd_pos_q     <= rd_pos_d;
      last_start_q <= last_start_d;
      last_len_q   <= last_len_d;
      drops_q      <= drops_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= ridx_d;
    out_q  <= out_d;
  end

  lfc_ring u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_pos_q),
    .wdata_i (in_data_i.rx_byte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lfc_match u_match (
    .clk_i         (clk_i),
    .chk_i         (chk),
    .rd_data_i     (ram_rdata),
    .line_len_i    (last_len_q),
    .line_type_o   (m_type),
    .bad_prefix_o  (m_bad),
    .alpha_valid_o (m_alpha)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LFC_ASSERT_IMPL(a_ptr_range, clk_i, rst_ni, 1'b1, (wr_pos_q <= RING_AW'(RING_DEPTH - 1)) && (rd_pos_q <= RING_AW'(RING_DEPTH - 1)))
  `LFC_ASSERT_IMPL(a_line_nonempty, clk_i, rst_ni, scan_q, wr_pos_q != rd_pos_q)
  `LFC_ASSERT_IMPL(a_alpha_report, clk_i, rst_ni, out_valid_o && out_data_o.alpha_valid, !out_data_o.is_read_reply && (out_data_o.line_type == TYPE_ALPHA) && (out_data_o.line_length == ALPHA_LEN))
  `LFC_ASSERT_NEXT(a_drops_monotonic, clk_i, rst_ni, 1'b1, drops_q >= $past(drops_q))
  `LFC_ASSERT_NEXT(a_check_ends, clk_i, rst_ni, (state_q == S_LINE) && (step_q == CHK_DONE), state_q == S_DONE)

endmodule

// ===== tb/sv/line_framer_with_type_classifier_core_tb.sv =====
// Self-checking testbench for the line framer with type classifier core.
module line_framer_with_type_classifier_core_tb;
  import lfc_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [31:0] LINE_TAGS [NUM_TAGS] = '{
    "LRR:", "REL:", "EXP:", "RFX:", "AUI:", "KPM:", "KPE:", "CRC:", "VER:", "ERR:"
  };

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  lfc_in_t  in_data_i   = '0;
  logic     out_ready_i = 1'b0;
  logic     in_ready_o;
  logic     out_valid_o;
  lfc_out_t out_data_o;

  line_framer_with_type_classifier_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // Framer state as predicted
  logic               fr_collecting;
  logic [7:0]         fr_ring [RING_DEPTH];
  logic [RING_AW-1:0] fr_wr;
  logic [RING_AW-1:0] fr_head;
  logic [RING_AW-1:0] fr_last_start;
  logic [LEN_W-1:0]   fr_last_len;
  logic [DROP_W-1:0]  fr_drops;

  lfc_out_t    due_results [$];
  lfc_out_t    want_res;
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  bit          src_calm   = 1'b0;
  bit          sink_calm  = 1'b0;

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch %s: got %0h, want %0h", what, got, want);
    fail_count++;
  endtask

  task automatic compare_result(input lfc_out_t got, input lfc_out_t want);
    if (got.is_read_reply !== want.is_read_reply) begin
      note_mismatch("is_read_reply", got.is_read_reply, want.is_read_reply);
    end
    if (got.line_type !== want.line_type) begin
      note_mismatch("line_type", got.line_type, want.line_type);
    end
    if (got.line_length !== want.line_length) begin
      note_mismatch("line_length", got.line_length, want.line_length);
    end
    if (got.bad_prefix !== want.bad_prefix) begin
      note_mismatch("bad_prefix", got.bad_prefix, want.bad_prefix);
    end
    if (got.alpha_valid !== want.alpha_valid) begin
      note_mismatch("alpha_valid", got.alpha_valid, want.alpha_valid);
    end
    if (got.drop_count !== want.drop_count) begin
      note_mismatch("drop_count", got.drop_count, want.drop_count);
    end
    if (got.read_data !== want.read_data) begin
      note_mismatch("read_data", got.read_data, want.read_data);
    end
  endtask

  function automatic logic [7:0] line_byte(input logic [RING_AW-1:0] base,
                                           input logic [LEN_W-1:0] off);
    return fr_ring[RING_AW'(base + off)];
  endfunction

  task automatic restart_parse();
    fr_wr         = '0;
    fr_head       = '0;
    fr_collecting = 1'b0;
  endtask

  task automatic reset_framer();
    foreach (fr_ring[i]) fr_ring[i] = '0;
    restart_parse();
    fr_last_start = '0;
    fr_last_len   = '0;
    fr_drops      = '0;
  endtask

  task automatic store_byte(input logic [7:0] b);
    fr_ring[fr_wr] = b;
    fr_wr = fr_wr + 1'b1;
    if (fr_wr == fr_head) begin
      if (fr_drops != '1) fr_drops = fr_drops + 1'b1;
      fr_head = fr_head + 1'b1;
    end
  endtask

  task automatic frame_step(input lfc_in_t it);
    lfc_out_t         res;
    logic             printable;
    logic [LEN_W-1:0] len;
    res = '0;
    printable = (it.rx_byte >= PRINT_LO) && (it.rx_byte <= PRINT_HI);
    case (it.cmd)
      CMD_RX: begin
        if (!fr_collecting) begin
          if (printable) begin
            fr_collecting = 1'b1;
            store_byte(it.rx_byte);
          end
        end else if (it.rx_byte == CHAR_CR || it.rx_byte == CHAR_LF) begin
          len = LEN_W'(fr_wr - fr_head);
          if (line_byte(fr_head, 0) == CHAR_BANG) begin
            if (len >= PREFIX_LEN) begin
              for (int t = NUM_TAGS - 1; t >= 0; t--) begin
                if ({line_byte(fr_head, 1), line_byte(fr_head, 2), line_byte(fr_head, 3),
                     line_byte(fr_head, 4)} == LINE_TAGS[t]) begin
                  res.line_type = TYPE_W'(t + 1);
                end
              end
            end
          end else if (line_byte(fr_head, 0) == CHAR_BRACKET) begin
            res.line_type   = TYPE_ALPHA;
            res.alpha_valid = (len == ALPHA_LEN) &&
                              (line_byte(fr_head, QUOTE_POS) == CHAR_QUOTE) &&
                              (line_byte(fr_head, COMMA_POS) == CHAR_COMMA);
          end else begin
            res.bad_prefix = 1'b1;
          end
          fr_last_start   = fr_head;
          fr_last_len     = len;
          fr_head         = fr_wr;
          fr_collecting   = 1'b0;
          res.line_length = len;
          res.drop_count  = fr_drops;
          due_results     = {due_results, res};
        end else if (!printable) begin
          restart_parse();
        end else begin
          store_byte(it.rx_byte);
        end
      end
      CMD_READ: begin
        res.is_read_reply = 1'b1;
        res.line_length   = fr_last_len;
        res.drop_count    = fr_drops;
        res.read_data     = (it.read_index < fr_last_len) ?
                            line_byte(fr_last_start, it.read_index) : 8'h00;
        due_results       = {due_results, res};
      end
      CMD_RESTART: restart_parse();
      default: ;
    endcase
  endtask

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [7:0] printable_rand();
    return 8'($urandom_range(PRINT_HI, PRINT_LO));
  endfunction

  function automatic logic [7:0] ctrl_rand();
    logic [7:0] b;
    do b = 8'($urandom);
    while ((b >= PRINT_LO && b <= PRINT_HI) || b == CHAR_CR || b == CHAR_LF);
    return b;
  endfunction

  task automatic push_item(input logic [1:0] c, input logic [7:0] b, input logic [6:0] ix);
    int unsigned gap;
    lfc_in_t     it;
    bit          taken;
    gap = pick_gap(src_calm);
    it.cmd        = c;
    it.rx_byte    = b;
    it.read_index = ix;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    frame_step(it);
    items_sent++;
  endtask

  task automatic push_rx(input logic [7:0] b);
    push_item(CMD_RX, b, 7'($urandom));
  endtask

  task automatic push_read(input logic [6:0] ix);
    push_item(CMD_READ, 8'($urandom), ix);
  endtask

  task automatic push_restart();
    push_item(CMD_RESTART, 8'($urandom), 7'($urandom));
  endtask

  task automatic push_eol();
    push_rx($urandom_range(1) ? CHAR_CR : CHAR_LF);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_rx(s[i]);
  endtask

  task automatic push_tag(input logic [31:0] w);
    for (int k = 3; k >= 0; k--) push_rx(w[8*k +: 8]);
  endtask

  task automatic push_body(input int unsigned n);
    repeat (n) push_rx(printable_rand());
  endtask

  task automatic push_alpha(input int unsigned len, input bit comma_ok, input bit quote_ok);
    for (int unsigned i = 0; i < len; i++) begin
      if (i == 0) push_rx(CHAR_BRACKET);
      else if (i == COMMA_POS) push_rx(comma_ok ? CHAR_COMMA : CHAR_QUOTE);
      else if (i == QUOTE_POS) push_rx(quote_ok ? CHAR_QUOTE : CHAR_COMMA);
      else push_rx(printable_rand());
    end
    push_eol();
  endtask

  // Hold off the sender until every result is in.
  task automatic wait_all_reported();
    in_valid_i <= 1'b0;
    do @(posedge clk_i);
    while (due_results.size() != 0);
  endtask

  function automatic logic [6:0] pick_index();
    if ($urandom_range(3) == 0) return 7'($urandom);
    return 7'($urandom_range(fr_last_len));
  endfunction

  task automatic push_random_line();
    int unsigned kind;
    logic [31:0] tag;
    logic [7:0]  first;
    kind = $urandom_range(9);
    if ($urandom_range(7) == 0) push_rx(ctrl_rand());
    case (kind)
      0, 1, 2, 3: begin
        tag = LINE_TAGS[$urandom_range(NUM_TAGS - 1)];
        if ($urandom_range(4) == 0) tag[8*$urandom_range(3) +: 8] = printable_rand();
        push_rx(CHAR_BANG);
        push_tag(tag);
        push_body($urandom_range(24));
        push_eol();
      end
      4: begin
        tag = LINE_TAGS[$urandom_range(NUM_TAGS - 1)];
        push_rx(CHAR_BANG);
        for (int k = 3; k > 3 - int'($urandom_range(3)); k--) push_rx(tag[8*k +: 8]);
        push_eol();
      end
      5: begin
        push_alpha(($urandom_range(3) == 0) ? $urandom_range(120, 1) : ALPHA_LEN,
                   $urandom_range(3) != 0, $urandom_range(3) != 0);
      end
      6: begin
        do first = printable_rand();
        while (first == CHAR_BANG || first == CHAR_BRACKET);
        push_rx(first);
        push_body($urandom_range(30));
        push_eol();
      end
      7: begin
        case ($urandom_range(2))
          0: push_rx(CHAR_BANG);
          1: push_rx(CHAR_BRACKET);
          default: push_rx(printable_rand());
        endcase
        push_body($urandom_range(200, 100));
        push_eol();
      end
      8: begin
        push_rx(($urandom_range(1) != 0) ? CHAR_BANG : printable_rand());
        push_body($urandom_range(30));
        if ($urandom_range(1) != 0) push_rx(ctrl_rand());
        else push_restart();
      end
      default: begin
        push_rx(CHAR_BANG);
        push_body($urandom_range(30, 4));
        push_eol();
      end
    endcase
  endtask

  task automatic test_ring_fill_overflow();
    push_rx(8'h00);
    push_rx(8'hFF);
    push_rx(CHAR_CR);
    push_rx(CHAR_LF);
    push_rx(8'h7F);
    for (int i = 0; i < 130; i++) push_rx(PRINT_LO + 8'(i % 95));
    push_rx(CHAR_LF);
    push_read(7'd0);
    push_read(7'd126);
    push_read(7'd127);
  endtask

  task automatic test_line_types();
    for (int t = 0; t < NUM_TAGS; t++) begin
      push_rx(CHAR_BANG);
      push_tag(LINE_TAGS[t]);
      push_rx(printable_rand());
      push_eol();
    end
    push_text("!LR");
    push_rx(CHAR_LF);
    push_text("!LRR");
    push_rx(CHAR_CR);
    push_text("!ABC:9");
    push_rx(CHAR_CR);
    push_text("hello");
    push_rx(CHAR_LF);
  endtask

  task automatic test_alpha_check();
    push_alpha(ALPHA_LEN, 1'b1, 1'b1);
    push_read(COMMA_POS);
    push_read(QUOTE_POS);
    push_alpha(ALPHA_LEN, 1'b0, 1'b1);
    push_alpha(ALPHA_LEN, 1'b1, 1'b0);
    push_alpha(95, 1'b1, 1'b1);
    push_alpha(93, 1'b1, 1'b1);
    push_alpha(1, 1'b1, 1'b1);
  endtask

  task automatic test_read_commands();
    push_read(7'd0);
    push_read(7'd1);
    push_read(7'd127);
    push_text("~readback ");
    push_rx(CHAR_CR);
    push_read(7'd9);
    push_read(7'd10);
    push_item(CMD_UNUSED, 8'hFF, 7'h7F);
    push_item(CMD_UNUSED, 8'h00, 7'h00);
    push_read(7'd0);
  endtask

  task automatic test_abandoned_lines();
    push_text("!LRR:123");
    push_rx(8'h1B);
    push_rx(CHAR_LF);
    push_text("abc");
    push_restart();
    push_text("!KPM:x");
    push_rx(CHAR_CR);
    push_read(7'd1);
    push_text("zz");
    push_rx(8'h80);
    push_text("Q");
    push_rx(CHAR_LF);
    push_text("WXYZ");
    push_read(7'd0);
    push_read(7'd1);
    push_restart();
    push_read(7'd0);
  endtask

  task automatic test_random_traffic();
    int unsigned goal;
    int unsigned next_mode;
    int unsigned r;
    bit          paused;
    goal      = items_sent + 1000;
    next_mode = items_sent + 150;
    paused    = 1'b0;
    while (items_sent < goal) begin
      r = $urandom_range(99);
      if (r < 60) push_random_line();
      else if (r < 80) push_read(pick_index());
      else if (r < 90) push_rx(8'($urandom));
      else if (r < 95) push_restart();
      else push_item(CMD_UNUSED, 8'($urandom), 7'($urandom));
      if (items_sent >= next_mode) begin
        src_calm  = ($urandom_range(3) == 0);
        sink_calm = ($urandom_range(3) == 0);
        next_mode = items_sent + 150;
      end
      if (!paused && items_sent + 500 >= goal) begin
        wait_all_reported();
        paused = 1'b1;
      end
    end
    src_calm  = 1'b0;
    sink_calm = 1'b0;
  endtask

  initial begin
    @(posedge clk_i);
    forever begin
      int unsigned hold;
      hold = pick_gap(sink_calm);
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_results.size() == 0) begin
        note_mismatch("unexpected result", out_data_o, '0);
      end else begin
        want_res = due_results.pop_front();
        compare_result(out_data_o, want_res);
      end
    end
  end

  initial begin
    #60_000_000;
    $display("** line_framer_with_type_classifier_core: FAILED **");
    $finish;
  end

  initial begin
    reset_framer();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_ring_fill_overflow();
    test_line_types();
    test_alpha_check();
    test_read_commands();
    test_abandoned_lines();
    test_random_traffic();
    wait_all_reported();
    repeat (30) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** line_framer_with_type_classifier_core: PASSED **");
    end else begin
      $display("** line_framer_with_type_classifier_core: FAILED **");
    end
    $finish;
  end

endmodule
